>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that cond holds in the cycle after trig
`define ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> hw/rtl/sh128_pkg.sv
// ----------------------------------------------------------------------------
// sh128_pkg
// Constants, microcode format, control program and SipRound for the
// streaming SipHash-2-4 128-bit block.
// ----------------------------------------------------------------------------
package sh128_pkg;

    localparam logic [63:0] SIP_C0   = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1   = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2   = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3   = 64'h7465646279746573;
    localparam logic [63:0] SIP_MODE = 64'h00000000000000ee;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    typedef logic [3:0] step_t;

    localparam step_t STEP_WAIT    = 4'd0;
    localparam step_t STEP_ROUND_A = 4'd1;
    localparam step_t STEP_ROUND_B = 4'd2;
    localparam step_t STEP_TAIL    = 4'd3;
    localparam step_t STEP_FIN0    = 4'd4;
    localparam step_t STEP_FIN1    = 4'd5;
    localparam step_t STEP_FIN2    = 4'd6;
    localparam step_t STEP_FIN3    = 4'd7;
    localparam step_t STEP_EMIT    = 4'd8;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_INPUT,
        JMP_WORD,
        JMP_OUTPUT
    } jump_t;

    typedef struct packed {
        logic  accept;
        logic  round;
        logic  pre_m;
        logic  pre_mode;
        logic  post_m;
        logic  load_tail;
        logic  emit;
        jump_t jump;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic full;
        logic last;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } lanes_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '0;
        case (step)
            STEP_WAIT:
            begin
                w.accept = 1'b1;
                w.jump   = JMP_INPUT;
            end
            STEP_ROUND_A:
            begin
                w.round = 1'b1;
                w.pre_m = 1'b1;
            end
            STEP_ROUND_B:
            begin
                w.round  = 1'b1;
                w.post_m = 1'b1;
                w.jump   = JMP_WORD;
                w.target = STEP_FIN0;
            end
            STEP_TAIL:
            begin
                w.load_tail = 1'b1;
                w.jump      = JMP_GOTO;
                w.target    = STEP_ROUND_A;
            end
            STEP_FIN0:
            begin
                w.round    = 1'b1;
                w.pre_mode = 1'b1;
            end
            STEP_FIN1, STEP_FIN2, STEP_FIN3:
            begin
                w.round = 1'b1;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.jump   = JMP_OUTPUT;
                w.target = STEP_WAIT;
            end
            default:
            begin
                w.jump   = JMP_GOTO;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    function automatic lanes_t sip_round(input lanes_t s);
        lanes_t      r;
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
        v0 = s.v0 + s.v1;
        v1 = {s.v1[50:0], s.v1[63:51]} ^ v0;
        v0 = {v0[31:0], v0[63:32]};
        v2 = s.v2 + s.v3;
        v3 = {s.v3[47:0], s.v3[63:48]} ^ v2;
        v0 = v0 + v3;
        v3 = {v3[42:0], v3[63:43]} ^ v0;
        v2 = v2 + v1;
        v1 = {v1[46:0], v1[63:47]} ^ v2;
        v2 = {v2[31:0], v2[63:32]};
        r.v0 = v0;
        r.v1 = v1;
        r.v2 = v2;
        r.v3 = v3;
        return r;
    endfunction

endpackage

>>> hw/rtl/sh128_seq.sv
// ----------------------------------------------------------------------------
// sh128_seq
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module sh128_seq
    import sh128_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t status,
    output ucode_t     ctrl
);

    step_t pc_reg;
    step_t pc_next;
    step_t pc_inc;

    always_comb
    begin
        ctrl   = ucode_rom(pc_reg);
        pc_inc = pc_reg + step_t'(1);
        case (ctrl.jump)
            JMP_NEXT:   pc_next = pc_inc;
            JMP_GOTO:   pc_next = ctrl.target;
            JMP_INPUT:  pc_next = in_valid ? pc_inc : pc_reg;
            JMP_WORD:
            begin
                if (!status.full)
                    pc_next = ctrl.target;
                else if (!status.last)
                    pc_next = STEP_WAIT;
                else
                    pc_next = pc_inc;
            end
            JMP_OUTPUT: pc_next = status.out_free ? ctrl.target : pc_reg;
            default:    pc_next = STEP_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_WAIT;
        else
            pc_reg <= pc_next;
    end

endmodule

>>> hw/rtl/sh128_dp.sv
// ----------------------------------------------------------------------------
// sh128_dp
// Lane datapath: key registers, message block, one SipRound per cycle,
// byte count and the output register.
// ----------------------------------------------------------------------------
module sh128_dp
    import sh128_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ucode_t               ctrl,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_wdata,
    input  logic                 in_valid,
    input  logic [63:0]          data_word,
    input  logic [3:0]           byte_count,
    input  logic                 last,
    input  logic                 out_ready,
    output dp_status_t           status,
    output logic                 out_valid,
    output logic [63:0]          hash_low,
    output logic [63:0]          hash_high
);

    logic [63:0] key_low_reg, key_low_next;
    logic [63:0] key_high_reg, key_high_next;
    lanes_t      lanes_reg, lanes_next;
    logic [63:0] m_reg, m_next;
    logic [7:0]  len_reg, len_next;
    logic        inmsg_reg, inmsg_next;
    logic        full_reg, full_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] hash_low_reg, hash_low_next;
    logic [63:0] hash_high_reg, hash_high_next;

    logic        fire;
    logic        out_free;
    logic [3:0]  cnt;
    logic [7:0]  base_len;
    logic [7:0]  new_len;
    logic [63:0] tail;
    lanes_t      pre;
    lanes_t      post;

    assign fire     = ctrl.accept && in_valid;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cnt      = (byte_count > 4'd8) ? 4'd8 : byte_count;
        base_len = inmsg_reg ? len_reg : 8'd0;
        new_len  = base_len + {4'd0, cnt};
        tail     = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < cnt)
                tail[8*i +: 8] = data_word[8*i +: 8];
        end
        tail[63:56] = new_len;

        pre = lanes_reg;
        if (ctrl.pre_m)
            pre.v3 = pre.v3 ^ m_reg;
        if (ctrl.pre_mode)
            pre.v2 = pre.v2 ^ SIP_MODE;
        post = sip_round(pre);
        if (ctrl.post_m)
            post.v0 = post.v0 ^ m_reg;
    end

    always_comb
    begin
        key_low_next   = key_low_reg;
        key_high_next  = key_high_reg;
        lanes_next     = lanes_reg;
        m_next         = m_reg;
        len_next       = len_reg;
        inmsg_next     = inmsg_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        hash_low_next  = hash_low_reg;
        hash_high_next = hash_high_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_LOW:  key_low_next  = cfg_wdata;
                REG_KEY_HIGH: key_high_next = cfg_wdata;
                default:      ;
            endcase
        end

        if (fire)
        begin
            if (!inmsg_reg)
            begin
                lanes_next.v0 = SIP_C0 ^ key_low_reg;
                lanes_next.v1 = SIP_C1 ^ key_high_reg ^ SIP_MODE;
                lanes_next.v2 = SIP_C2 ^ key_low_reg;
                lanes_next.v3 = SIP_C3 ^ key_high_reg;
            end
            full_next  = (cnt == 4'd8);
            last_next  = last;
            m_next     = (cnt == 4'd8) ? data_word : tail;
            len_next   = new_len;
            inmsg_next = 1'b1;
        end

        if (ctrl.round)
            lanes_next = post;

        if (ctrl.load_tail)
        begin
            m_next    = {len_reg, 56'd0};
            full_next = 1'b0;
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (ctrl.emit && out_free)
        begin
            hash_low_next  = lanes_reg.v0 ^ lanes_reg.v1 ^ lanes_reg.v2 ^ lanes_reg.v3;
            hash_high_next = lanes_reg.v1 ^ lanes_reg.v3;
            out_valid_next = 1'b1;
            inmsg_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            lanes_reg     <= '0;
            len_reg       <= '0;
            inmsg_reg     <= 1'b0;
            full_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_low_reg   <= key_low_next;
            key_high_reg  <= key_high_next;
            lanes_reg     <= lanes_next;
            len_reg       <= len_next;
            inmsg_reg     <= inmsg_next;
            full_reg      <= full_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg         <= m_next;
        hash_low_reg  <= hash_low_next;
        hash_high_reg <= hash_high_next;
    end

    assign status.full     = full_reg;
    assign status.last     = last_reg;
    assign status.out_free = out_free;
    assign out_valid       = out_valid_reg;
    assign hash_low        = hash_low_reg;
    assign hash_high       = hash_high_reg;

endmodule

>>> hw/rtl/siphash_128_stream.sv
// ----------------------------------------------------------------------------
// siphash_128_stream
// Keyed SipHash-2-4, 128-bit mode with a custom output fold, over a byte
// message that arrives as little-endian 64-bit beats.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   cfg     | in        | cfg_we               | cfg_index, cfg_wdata
//   in      | in        | in_valid / in_ready  | data_word, byte_count, last
//   out     | out       | out_valid / out_ready| hash_low, hash_high
//
// A non-final full beat is accepted, then runs two SipRounds, one round per
// cycle in the shared round unit.
// A closing short beat goes on to four finalization rounds and the emit step;
// a closing full beat first adds an extra tail block. Emit registers the result.
// The result register holds one hash; the next beat is taken while it waits,
// and a following close stalls at its emit step until the register drains.
// Reset clears keys, lanes, count and all control state.
// ----------------------------------------------------------------------------
module siphash_128_stream
    import sh128_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [63:0]          data_word,
    input  logic [3:0]           byte_count,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          hash_low,
    output logic [63:0]          hash_high
);

    ucode_t     ctrl;
    dp_status_t status;

    sh128_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    sh128_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .out_ready  (out_ready),
        .status     (status),
        .out_valid  (out_valid),
        .hash_low   (hash_low),
        .hash_high  (hash_high)
    );

    assign in_ready = ctrl.accept;

endmodule

>>> hw/rtl/sh128_check.sv
// ----------------------------------------------------------------------------
// sh128_check
// Port-level checks for siphash_128_stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sh128_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] hash_low,
    input logic [63:0] hash_high
);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
    `ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(hash_low) && $stable(hash_high), "result changed while stalled")
    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "beat taken while rounds pending")
    `ASSERT_CLK(a_emit_while_busy, $rose(out_valid) |-> !$past(in_ready), "result without finalization")

endmodule

bind siphash_128_stream sh128_check u_check (.*);

>>> sim/siphash_128_stream_test.sv
// ----------------------------------------------------------------------------
// siphash_128_stream_test
// Self-checking bench for the streaming SipHash-2-4 128-bit block. Messages
// of little-endian beats go in through a valid/ready channel with random
// gaps. A tracker class keeps its own lanes, byte count and key, predicts the
// hash of every closed message and compares each hash taken from the output
// channel, which stalls at random. The key is rewritten between phases,
// including while a message is still open.
// ----------------------------------------------------------------------------
module siphash_128_stream_test
    import sh128_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
    } hash_pair_t;

    class hash_tracker;
        localparam logic [63:0] INIT_V0   = 64'h736f6d6570736575;
        localparam logic [63:0] INIT_V1   = 64'h646f72616e646f6d;
        localparam logic [63:0] INIT_V2   = 64'h6c7967656e657261;
        localparam logic [63:0] INIT_V3   = 64'h7465646279746573;
        localparam logic [63:0] MODE_BYTE = 64'h00000000000000ee;

        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [63:0] lane0;
        logic [63:0] lane1;
        logic [63:0] lane2;
        logic [63:0] lane3;
        logic [7:0]  msg_len;
        bit          msg_open;
        hash_pair_t  pending_hashes[$];
        int          errors;

        function new();
            key_lo   = '0;
            key_hi   = '0;
            lane0    = '0;
            lane1    = '0;
            lane2    = '0;
            lane3    = '0;
            msg_len  = '0;
            msg_open = 1'b0;
            errors   = 0;
        endfunction

        function void set_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
            if (idx == REG_KEY_LOW)
                key_lo = value;
            else
                key_hi = value;
        endfunction

        function logic [63:0] rotl(logic [63:0] x, int unsigned r);
            return (x << r) | (x >> (64 - r));
        endfunction

        function void mix_round();
            lane0 = lane0 + lane1;
            lane1 = rotl(lane1, 13) ^ lane0;
            lane0 = rotl(lane0, 32);
            lane2 = lane2 + lane3;
            lane3 = rotl(lane3, 16) ^ lane2;
            lane0 = lane0 + lane3;
            lane3 = rotl(lane3, 21) ^ lane0;
            lane2 = lane2 + lane1;
            lane1 = rotl(lane1, 17) ^ lane2;
            lane2 = rotl(lane2, 32);
        endfunction

        function void absorb_word(logic [63:0] m);
            lane3 = lane3 ^ m;
            mix_round();
            mix_round();
            lane0 = lane0 ^ m;
        endfunction

        function void note_beat(logic [63:0] word, logic [3:0] count, logic is_last);
            int unsigned n;
            logic [63:0] tail;
            hash_pair_t  h;
            n = (count > 4'd8) ? 8 : count;
            if (!msg_open)
            begin
                lane0    = INIT_V0 ^ key_lo;
                lane1    = INIT_V1 ^ key_hi ^ MODE_BYTE;
                lane2    = INIT_V2 ^ key_lo;
                lane3    = INIT_V3 ^ key_hi;
                msg_len  = '0;
                msg_open = 1'b1;
            end
            if (n == 8)
            begin
                absorb_word(word);
                msg_len = msg_len + 8'd8;
                if (!is_last)
                    return;
                tail = '0;
            end
            else
            begin
                tail    = (n == 0) ? 64'h0 : (word & ((64'h1 << (8 * n)) - 64'h1));
                msg_len = msg_len + 8'(n);
            end
            tail[63:56] = msg_len;
            absorb_word(tail);
            lane2 = lane2 ^ MODE_BYTE;
            repeat (4) mix_round();
            h.low  = lane0 ^ lane1 ^ lane2 ^ lane3;
            h.high = lane1 ^ lane3;
            pending_hashes.push_back(h);
            msg_open = 1'b0;
        endfunction

        function void check_hash(logic [63:0] low, logic [63:0] high);
            hash_pair_t h;
            if (pending_hashes.size() == 0)
            begin
                $display("%0t: unexpected hash, expected none, got low=%h high=%h",
                         $time, low, high);
                errors++;
                return;
            end
            h = pending_hashes.pop_front();
            if (low !== h.low)
            begin
                $display("%0t: hash_low mismatch, expected %h, got %h", $time, h.low, low);
                errors++;
            end
            if (high !== h.high)
            begin
                $display("%0t: hash_high mismatch, expected %h, got %h",
                         $time, h.high, high);
                errors++;
            end
        endfunction

        function int pending();
            return pending_hashes.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [63:0]          cfg_wdata  = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic [63:0]          data_word  = '0;
    logic [3:0]           byte_count = '0;
    logic                 last       = 1'b0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic [63:0]          hash_low;
    logic [63:0]          hash_high;

    hash_tracker tracker;
    int          beats_sent   = 0;
    bit          source_burst = 1'b0;
    bit          sink_burst   = 1'b0;

    siphash_128_stream u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_low   (hash_low),
        .hash_high  (hash_high)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("siphash_128_stream test failed");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_beat(input logic [63:0] word, input logic [3:0] count,
                             input logic is_last);
        int gap;
        if ($urandom_range(0, 15) == 0)
            source_burst = !source_burst;
        gap = source_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= word;
        byte_count <= count;
        last       <= is_last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_beat(word, count, is_last);
        beats_sent++;
    endtask

    task automatic send_full_words(input int n);
        logic [3:0] count;
        repeat (n)
        begin
            count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
            send_beat(rand_word(), count, 1'b0);
        end
    endtask

    // tail_bytes of 8 closes with a full beat flagged last
    task automatic send_message(input int full_words, input int tail_bytes);
        logic [3:0] count;
        send_full_words(full_words);
        if (tail_bytes == 8)
        begin
            count = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
            send_beat(rand_word(), count, 1'b1);
        end
        else
            send_beat(rand_word(), 4'(tail_bytes), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(input int beats, input bit leave_open);
        int first;
        int words;
        first = beats_sent;
        while (beats_sent - first < beats)
        begin
            words = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 4);
            send_message(words, $urandom_range(0, 8));
        end
        if (leave_open)
            send_full_words($urandom_range(1, 3));
    endtask

    // drop valid, drain expected hashes, then let the block finish its rounds
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_key(idx, value);
        @(posedge clk);
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_hash(hash_low, hash_high);
    end

    initial
    begin
        int phase;
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(ALL_ONES, 4'd0, 1'b1);
        send_beat(ALL_ONES, 4'd0, 1'b0);
        send_beat(ALL_ONES, 4'd7, 1'b0);
        send_beat(64'h0, 4'd1, 1'b1);
        send_beat(ALL_ONES, 4'd8, 1'b1);
        send_beat(64'h0, 4'd8, 1'b0);
        send_beat(ALL_ONES, 4'd15, 1'b0);
        send_beat(64'h0123456789abcdef, 4'd9, 1'b1);
        send_beat(ALL_ONES, 4'd8, 1'b0);
        send_beat(ALL_ONES, 4'd3, 1'b1);
        send_beat(64'h8000000000000001, 4'd12, 1'b0);
        send_beat(64'h0, 4'd0, 1'b1);
        send_beat(64'hfedcba9876543210, 4'd6, 1'b1);
        send_beat(ALL_ONES, 4'd4, 1'b0);
        send_beat(ALL_ONES, 4'd2, 1'b1);
        send_beat(ALL_ONES, 4'd8, 1'b0);
        settle();

        // change key with a message open; it must not take effect until the next one
        write_reg(REG_KEY_LOW, ALL_ONES);
        write_reg(REG_KEY_HIGH, ALL_ONES);
        send_beat(ALL_ONES, 4'd5, 1'b0);
        send_beat(64'h0, 4'd8, 1'b1);

        for (phase = 0; phase < 4; phase++)
        begin
            run_phase(110, phase < 3 && $urandom_range(0, 1) == 1);
            settle();
            case (phase)
                0:
                begin
                    write_reg(REG_KEY_LOW, 64'h0);
                    write_reg(REG_KEY_HIGH, ALL_ONES);
                end
                1:
                begin
                    write_reg(REG_KEY_LOW, {$urandom, $urandom});
                    write_reg(REG_KEY_HIGH, {$urandom, $urandom});
                end
                2:
                begin
                    write_reg(REG_KEY_LOW, ALL_ONES);
                    write_reg(REG_KEY_HIGH, 64'h0);
                end
                default:
                begin
                end
            endcase
        end

        if (tracker.errors == 0)
            $display("siphash_128_stream test passed");
        else
            $display("siphash_128_stream test failed");
        $finish;
    end

endmodule
